>>> design/sat_pkg.sv
package sat_pkg;

   // Table size default and fixed widths
   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int IDX_CMP_W        = 8;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Stream widths; the tdata widths are padded to whole bytes
   localparam int REQ_TDATA_W = 200;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_LENGTH     = 1'b1;

   // Commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_V2F   = 2'd1;
   localparam logic [1:0] CMD_F2V   = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SEG   = 2'd1;
   localparam logic [1:0] STATUS_NOT_FILE = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic        wr_en;
      logic [3:0]  entry_index;
      logic [63:0] address;
      logic [31:0] read_length;
      logic [31:0] seg_virtual_size;
      logic [31:0] seg_file_size;
      logic [31:0] seg_file_offset;
      logic        seg_executable;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic        segment_found;
      logic        executable;
      logic        within_file;
      logic [63:0] mapped_value;
      logic [1:0]  status;
   } result_type;

endpackage

>>> design/sat_front.sv
module sat_front #(
   parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sat_pkg::item_type   req_item,
   input  sat_pkg::q_stat_type q_stat,
   output logic                push,
   output sat_pkg::item_type   push_item
);
   import sat_pkg::*;

   logic     fr_valid_ff, fr_valid_in;
   item_type fr_item_ff, fr_item_in;
   item_type classified;
   logic     accept;

   // Tag writes that land inside the table; others are dropped later
   always_comb begin
      classified       = req_item;
      classified.wr_en = (req_item.command == CMD_WRITE) &&
                         (IDX_CMP_W'(req_item.entry_index) < IDX_CMP_W'(MAX_SEGMENTS));
   end

   assign req_ready = !fr_valid_ff || !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign push      = fr_valid_ff && !q_stat.full;
   assign push_item = fr_item_ff;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_item_in  = fr_item_ff;
      if (accept) begin
         fr_valid_in = 1'b1;
         fr_item_in  = classified;
      end else if (push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_item_ff <= fr_item_in;
   end

endmodule

>>> design/sat_queue.sv
module sat_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sat_pkg::item_type   push_item,
   input  logic                pop,
   output sat_pkg::item_type   pop_item,
   output sat_pkg::q_stat_type q_stat
);
   import sat_pkg::*;

   item_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.empty = (count_ff == QCNT_W'(0));
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_item     = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/sat_back.sv
module sat_back #(
   parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sat_pkg::item_type                 q_item,
   input  sat_pkg::q_stat_type               q_stat,
   output logic                              q_pop,
   input  logic                              csr_wen,
   input  logic [sat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sat_pkg::result_type               rsp_result
);
   import sat_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_SEL  = 3'd2;
   localparam logic [2:0] S_REL  = 3'd3;
   localparam logic [2:0] S_MAP  = 3'd4;
   localparam logic [2:0] S_FIT  = 3'd5;

   // Segment table
   logic [63:0] base_ff  [MAX_SEGMENTS];
   logic [31:0] vsize_ff [MAX_SEGMENTS];
   logic [31:0] fsize_ff [MAX_SEGMENTS];
   logic [31:0] foff_ff  [MAX_SEGMENTS];
   logic        exec_ff  [MAX_SEGMENTS];
   logic        tbl_we;

   // Configuration
   logic [4:0]  seg_in_use_ff, seg_in_use_in;
   logic [31:0] flen_ff, flen_in;

   // Sequencer and working registers
   logic [2:0]              state_ff, state_in;
   item_type                item_ff, item_in;
   logic [MAX_SEGMENTS-1:0] hit_ff, hit_in;
   logic [63:0]             sel_base_ff, sel_base_in;
   logic [31:0]             sel_fsize_ff, sel_fsize_in;
   logic [31:0]             sel_foff_ff, sel_foff_in;
   logic                    sel_exec_ff, sel_exec_in;
   logic                    any_hit_ff, any_hit_in;
   logic [63:0]             rel_ff, rel_in;
   logic                    contained_ff, contained_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [63:0]             res_mapped_ff, res_mapped_in;
   logic                    res_exec_ff, res_exec_in;
   logic                    res_found_ff, res_found_in;
   logic                    res_ok_ff, res_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff, rsp_data_in;

   logic [MAX_SEGMENTS-1:0] fwd_hit, rev_hit, onehot;
   logic                    fwd, out_free, not_file;
   logic [63:0]             fit_sum, fwd_off, rev_va;

   assign fwd        = (item_ff.command == CMD_V2F);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

   // Per-entry compare against the address, in-use entries only (forward: segment end only)
   always_comb begin
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         fwd_hit[i] = ({3'b0, seg_in_use_ff} > IDX_CMP_W'(i)) &&
                      ((base_ff[i] + 64'(vsize_ff[i])) > item_ff.address);
         rev_hit[i] = ({3'b0, seg_in_use_ff} > IDX_CMP_W'(i)) &&
                      (item_ff.address >= 64'(foff_ff[i])) &&
                      (item_ff.address <
                       64'({1'b0, foff_ff[i]} + {1'b0, fsize_ff[i]}));
      end
   end

   // Lowest matching entry wins
   assign onehot = hit_ff & (~hit_ff + (MAX_SEGMENTS)'(1));

   assign not_file = rel_ff >= 64'(sel_fsize_ff);
   assign fwd_off  = 64'(sel_foff_ff) + rel_ff;
   assign rev_va   = sel_base_ff + rel_ff;
   assign fit_sum  = (fwd ? res_mapped_ff : item_ff.address) + 64'(item_ff.read_length);

   // Configuration writes
   always_comb begin
      seg_in_use_in = seg_in_use_ff;
      flen_in       = flen_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_SEGMENTS_IN_USE: seg_in_use_in = csr_wdata[4:0];
            CSR_FILE_LENGTH:     flen_in       = csr_wdata;
            default:             ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      hit_in        = hit_ff;
      sel_base_in   = sel_base_ff;
      sel_fsize_in  = sel_fsize_ff;
      sel_foff_in   = sel_foff_ff;
      sel_exec_in   = sel_exec_ff;
      any_hit_in    = any_hit_ff;
      rel_in        = rel_ff;
      contained_in  = contained_ff;
      res_status_in = res_status_ff;
      res_mapped_in = res_mapped_ff;
      res_exec_in   = res_exec_ff;
      res_found_in  = res_found_ff;
      res_ok_in     = res_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      tbl_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            res_mapped_in = '0;
            res_exec_in   = 1'b0;
            res_found_in  = 1'b0;
            res_ok_in     = 1'b0;
            case (item_ff.command)
               CMD_WRITE: begin
                  tbl_we        = item_ff.wr_en;
                  res_status_in = STATUS_OK;
                  state_in      = S_FIT;
               end
               CMD_V2F: begin
                  hit_in   = fwd_hit;
                  state_in = S_SEL;
               end
               CMD_F2V: begin
                  hit_in   = rev_hit;
                  state_in = S_SEL;
               end
               default: begin
                  res_status_in = STATUS_NO_SEG;
                  state_in      = S_FIT;
               end
            endcase
         end
         S_SEL: begin
            sel_base_in  = '0;
            sel_fsize_in = '0;
            sel_foff_in  = '0;
            sel_exec_in  = 1'b0;
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
               sel_base_in  = sel_base_in  | (onehot[i] ? base_ff[i]  : 64'd0);
               sel_fsize_in = sel_fsize_in | (onehot[i] ? fsize_ff[i] : 32'd0);
               sel_foff_in  = sel_foff_in  | (onehot[i] ? foff_ff[i]  : 32'd0);
               sel_exec_in  = sel_exec_in  | (onehot[i] & exec_ff[i]);
            end
            any_hit_in = |hit_ff;
            state_in   = S_REL;
         end
         S_REL: begin
            rel_in       = item_ff.address - (fwd ? sel_base_ff : 64'(sel_foff_ff));
            contained_in = any_hit_ff && (!fwd || (item_ff.address >= sel_base_ff));
            state_in     = S_MAP;
         end
         S_MAP: begin
            if (!contained_ff) begin
               res_status_in = STATUS_NO_SEG;
               res_mapped_in = '0;
               res_exec_in   = 1'b0;
               res_found_in  = 1'b0;
               res_ok_in     = 1'b0;
            end else if (fwd && not_file) begin
               res_status_in = STATUS_NOT_FILE;
               res_mapped_in = '0;
               res_exec_in   = sel_exec_ff;
               res_found_in  = 1'b1;
               res_ok_in     = 1'b0;
            end else begin
               res_status_in = STATUS_OK;
               res_mapped_in = fwd ? fwd_off : rev_va;
               res_exec_in   = sel_exec_ff;
               res_found_in  = 1'b1;
               res_ok_in     = 1'b1;
            end
            state_in = S_FIT;
         end
         S_FIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = res_status_ff;
               rsp_data_in.mapped_value  = res_mapped_ff;
               rsp_data_in.within_file   = res_ok_ff && (fit_sum <= 64'(flen_ff));
               rsp_data_in.executable    = res_exec_ff;
               rsp_data_in.segment_found = res_found_ff;
               if (!q_stat.empty) begin
                  q_pop    = 1'b1;
                  item_in  = q_item;
                  state_in = S_CMP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         seg_in_use_ff <= '0;
         flen_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         seg_in_use_ff <= seg_in_use_in;
         flen_ff       <= flen_in;
      end
      item_ff       <= item_in;
      hit_ff        <= hit_in;
      sel_base_ff   <= sel_base_in;
      sel_fsize_ff  <= sel_fsize_in;
      sel_foff_ff   <= sel_foff_in;
      sel_exec_ff   <= sel_exec_in;
      any_hit_ff    <= any_hit_in;
      rel_ff        <= rel_in;
      contained_ff  <= contained_in;
      res_status_ff <= res_status_in;
      res_mapped_ff <= res_mapped_in;
      res_exec_ff   <= res_exec_in;
      res_found_ff  <= res_found_in;
      res_ok_ff     <= res_ok_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Table entry write
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         if (tbl_we && (IDX_CMP_W'(item_ff.entry_index) == IDX_CMP_W'(i))) begin
            base_ff[i]  <= item_ff.address;
            vsize_ff[i] <= item_ff.seg_virtual_size;
            fsize_ff[i] <= item_ff.seg_file_size;
            foff_ff[i]  <= item_ff.seg_file_offset;
            exec_ff[i]  <= item_ff.seg_executable;
         end
      end
   end

endmodule

>>> design/segment_address_translator.sv
// The back end runs one item at a time; a lookup steps through compare, select,
// subtract, map and range check, and a write or unknown command through compare
// and range check. A 2-entry queue lets the front keep taking items while the
// back end works. Reset (synchronous, active high) clears the queue, control and
// both config registers; table entries hold no defined value until written.
module segment_address_translator #(
   parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index[3:0], address[67:4], read_length[99:68], seg_virtual_size[131:100],
   // seg_file_size[163:132], seg_file_offset[195:164], seg_executable[196]
   input  logic [sat_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command[1:0]
   input  logic [sat_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], mapped_value[65:2], within_file[66], executable[67],
   // segment_found[68]
   output logic [sat_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wen,
   input  logic [sat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sat_pkg::*;

   item_type   req_item, push_item, pop_item;
   q_stat_type q_stat;
   logic       push, pop;
   result_type result;

   // Unpack the request transfer
   always_comb begin
      req_item.command          = req_tuser[1:0];
      req_item.wr_en            = 1'b0;
      req_item.entry_index      = req_tdata[3:0];
      req_item.address          = req_tdata[67:4];
      req_item.read_length      = req_tdata[99:68];
      req_item.seg_virtual_size = req_tdata[131:100];
      req_item.seg_file_size    = req_tdata[163:132];
      req_item.seg_file_offset  = req_tdata[195:164];
      req_item.seg_executable   = req_tdata[196];
   end

   assign rsp_tdata = {3'b000, result.segment_found, result.executable,
                       result.within_file, result.mapped_value, result.status};

   sat_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   sat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   sat_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (pop_item),
      .q_stat     (q_stat),
      .q_pop      (pop),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

endmodule
